### rtl/core/four_level_page_table_walk_core_defines.svh
// Assertion macros shared by the page table walk RTL.
// Every check is sampled on the rising edge of clk and is switched off while arst_n is low.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALK_CORE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALK_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLTW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FLTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/fltw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fltw_pkg;

	// Table store geometry
	localparam int FRAMES      = 16;
	localparam int INDEX_BITS  = 9;
	localparam int FLAG_BITS   = 12;
	localparam int LEVELS      = 4;
	localparam int FRAME_BITS  = $clog2(FRAMES);
	localparam int SLOTS       = 1 << INDEX_BITS;
	localparam int STORE_WORDS = FRAMES * SLOTS;
	localparam int ADDR_W      = FRAME_BITS + INDEX_BITS;

	// Fixed field widths
	localparam int CMD_W      = 1;
	localparam int TFRAME_W   = 4;
	localparam int EIDX_W     = 9;
	localparam int ENTRY_W    = 64;
	localparam int VA_W       = 48;
	localparam int LEVEL_W    = 3;
	localparam int NEXT_W     = ENTRY_W - FLAG_BITS;
	localparam int STATUS_W   = 2;
	localparam int LVL_CNT_W  = $clog2(LEVELS);
	localparam int VA_REG_W   = FLAG_BITS + LEVELS * INDEX_BITS;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_WALK  = 1'b1;

	// Walk status codes
	localparam logic [STATUS_W-1:0] WS_PRESENT     = 2'd0;
	localparam logic [STATUS_W-1:0] WS_NOT_PRESENT = 2'd1;
	localparam logic [STATUS_W-1:0] WS_OUT_OF_RANGE = 2'd2;

endpackage

`default_nettype wire

### rtl/core/fltw_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: table writes and walk commands
interface fltw_req_if import fltw_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic [TFRAME_W-1:0]  table_frame;
	logic [EIDX_W-1:0]    entry_index;
	logic [ENTRY_W-1:0]   entry_data;
	logic [TFRAME_W-1:0]  root_frame;
	logic [VA_W-1:0]      virtual_address;

	modport source (output valid, cmd, table_frame, entry_index, entry_data, root_frame,
		virtual_address, input ready);
	modport sink (input valid, cmd, table_frame, entry_index, entry_data, root_frame,
		virtual_address, output ready);
endinterface

// Response channel: one transfer per level visited
interface fltw_rsp_if import fltw_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [LEVEL_W-1:0]   level;
	logic [ENTRY_W-1:0]   entry_word;
	logic [NEXT_W-1:0]    next_frame;
	logic [FLAG_BITS-1:0] entry_flags;
	logic [STATUS_W-1:0]  walk_status;
	logic                 last;

	modport source (output valid, level, entry_word, next_frame, entry_flags, walk_status,
		last, input ready);
	modport sink (input valid, level, entry_word, next_frame, entry_flags, walk_status,
		last, output ready);
endinterface

`default_nettype wire

### rtl/core/four_level_page_table_walk_core.sv
// Write command: stored in the table memory on the request transfer; no response.
// Walk command: per level, a table memory read and then an evaluate step; each level's
// response is registered from the evaluate step. An out-of-range frame skips the read and
// ends the walk with an out-of-range response. A full response register stalls the walk.
// Reset: arst_n (asynchronous, active low) idles the sequencer and empties the response
// register; the table memory is not cleared and must be written before it is walked.
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_walk_core_defines.svh"

module four_level_page_table_walk_core import fltw_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	fltw_req_if.sink   req,
	fltw_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EVAL = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Table memory
	logic [ENTRY_W-1:0] mem [0:STORE_WORDS-1];
	logic [ENTRY_W-1:0] rd_data_q;
	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;

	// Walk context
	logic [FRAME_BITS-1:0] frame_q;
	logic                  oor_q;
	logic [VA_REG_W-1:0]   va_q;
	logic [LVL_CNT_W-1:0]  lvl_q;

	// Response register
	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   out_level_q;
	logic [ENTRY_W-1:0]   out_word_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic                 out_last_q;

	logic                out_free, req_xfer;
	logic                emit, emit_last;
	logic [ENTRY_W-1:0]  emit_word;
	logic [STATUS_W-1:0] emit_status;
	logic                lvl_final;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign lvl_final = (lvl_q == LVL_CNT_W'(LEVELS - 1));

	assign mem_we  = req_xfer && (req.cmd == CMD_WRITE) && (32'(req.table_frame) < FRAMES);
	assign wr_addr = {FRAME_BITS'(req.table_frame), INDEX_BITS'(req.entry_index)};
	assign rd_addr = {frame_q, va_q[VA_REG_W-1 -: INDEX_BITS]};
	assign mem_re  = (state_q == ST_READ) && !oor_q;

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= req.entry_data;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Result selection and next state
	always_comb begin
		state_d     = state_q;
		emit        = 1'b0;
		emit_word   = rd_data_q;
		emit_status = WS_PRESENT;
		emit_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (req_xfer && req.cmd == CMD_WALK) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (oor_q) begin
					emit        = out_free;
					emit_word   = '0;
					emit_status = WS_OUT_OF_RANGE;
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				emit        = out_free;
				emit_status = rd_data_q[0] ? WS_PRESENT : WS_NOT_PRESENT;
				emit_last   = !rd_data_q[0] || lvl_final;
				if (out_free) begin
					state_d = emit_last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk context: load on a walk transfer, step after each present entry below the last level
	always_ff @(posedge clk) begin
		if (req_xfer && req.cmd == CMD_WALK) begin
			frame_q <= FRAME_BITS'(req.root_frame);
			oor_q   <= (32'(req.root_frame) >= FRAMES);
			va_q    <= VA_REG_W'(req.virtual_address);
			lvl_q   <= '0;
		end else if (state_q == ST_EVAL && emit && !emit_last) begin
			frame_q <= rd_data_q[FLAG_BITS +: FRAME_BITS];
			oor_q   <= (rd_data_q[ENTRY_W-1:FLAG_BITS] >= NEXT_W'(FRAMES));
			va_q    <= va_q << INDEX_BITS;
			lvl_q   <= lvl_q + 1'b1;
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_level_q  <= LEVEL_W'(lvl_q) + 1'b1;
			out_word_q   <= emit_word;
			out_status_q <= emit_status;
			out_last_q   <= emit_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.level       = out_level_q;
	assign rsp.entry_word  = out_word_q;
	assign rsp.next_frame  = out_word_q[ENTRY_W-1:FLAG_BITS];
	assign rsp.entry_flags = out_word_q[FLAG_BITS-1:0];
	assign rsp.walk_status = out_status_q;
	assign rsp.last        = out_last_q;

	// Checks
	`FLTW_ASSERT_SAME(a_idle_pending_last, req.ready && out_valid_q, out_last_q, "pending response while idle is not the last one")
	`FLTW_ASSERT_SAME(a_oor_zero_word, out_valid_q && out_status_q == WS_OUT_OF_RANGE, out_word_q == '0 && out_last_q, "out-of-range response carries data or is not last")
	`FLTW_ASSERT_SAME(a_status_present_bit, out_valid_q && out_status_q != WS_OUT_OF_RANGE, out_word_q[0] == (out_status_q == WS_PRESENT), "status disagrees with present bit")
	`FLTW_ASSERT_NEXT(a_continue_walk, out_valid_q && rsp.ready && !out_last_q, out_valid_q || state_q != ST_IDLE, "walk stopped after a non-final response")

endmodule

`default_nettype wire
